>>> rtl/ppt_pkg.sv
// Package for the position and profit tracker.
// Field widths, request codes, controller command and status structs.
// No dependencies.
package ppt_pkg;

   // request codes carried on the cmd field
   localparam logic CMD_TRADE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   // fixed field widths
   localparam int ACCT_W    = 8;
   localparam int PRICE_W   = 32;
   localparam int VOL_W     = 31;
   localparam int POS_W     = 32;
   localparam int AVG_OUT_W = 48;
   localparam int PNL_W     = 64;
   localparam int MPLIER_W  = 32;
   localparam int DIVISOR_W = 32;

   // parameter defaults
   localparam int DEF_ACCOUNT_COUNT   = 256;
   localparam int DEF_PRICE_FRAC_BITS = 16;

   // multiplier operand selects
   localparam logic [1:0] MSEL_ENTRY = 2'd0; // average * held quantity
   localparam logic [1:0] MSEL_FILL  = 2'd1; // trade price * volume
   localparam logic [1:0] MSEL_CLOSE = 2'd2; // price gap * closed volume
   localparam logic [1:0] MSEL_OPEN  = 2'd3; // last price gap * inventory

   // fill kinds
   localparam logic [1:0] KIND_OPEN   = 2'd0;
   localparam logic [1:0] KIND_ADD    = 2'd1;
   localparam logic [1:0] KIND_REDUCE = 2'd2;

   typedef struct packed {
      logic       clr_step;
      logic       take;
      logic       side_next;
      logic       rd;
      logic       mul_start;
      logic [1:0] mul_sel;
      logic       save_a;
      logic       div_start;
      logic       wr;
      logic       rsp_load;
   } cmd_type;

   typedef struct packed {
      logic       clr_done;
      logic       is_query;
      logic       side;
      logic       acct_ok;
      logic [1:0] kind;
      logic       open_nz;
      logic       mul_done;
      logic       div_done;
      logic       rsp_free;
   } status_type;

endpackage

>>> rtl/ppt_mul.sv
// Shift-add multiplier, one multiplier bit per cycle.
// Depends on ppt_pkg for the multiplier width.
module ppt_mul #(
   parameter int A_W = 48
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [A_W-1:0]                 mcand,
   input  logic [ppt_pkg::MPLIER_W-1:0]   mplier,
   output logic [A_W+ppt_pkg::MPLIER_W-1:0] prod,
   output logic                           busy
);
   import ppt_pkg::*;

   localparam int P_W  = A_W + MPLIER_W;
   localparam int CW   = $clog2(MPLIER_W);

   logic [P_W-1:0]      a_ff;
   logic [MPLIER_W-1:0] b_ff;
   logic [P_W-1:0]      acc_ff;
   logic [CW-1:0]       cnt_ff;
   logic                busy_ff;

   // control: run for one pass over the multiplier bits
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 1'b1;
         if (cnt_ff == CW'(MPLIER_W - 1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   // datapath: add the shifted multiplicand where the multiplier bit is set
   always_ff @(posedge clock) begin
      if (start) begin
         a_ff   <= P_W'(mcand);
         b_ff   <= mplier;
         acc_ff <= '0;
      end else if (busy_ff) begin
         if (b_ff[0]) begin
            acc_ff <= acc_ff + a_ff;
         end
         a_ff <= a_ff << 1;
         b_ff <= b_ff >> 1;
      end
   end

   assign prod = acc_ff;
   assign busy = busy_ff;

endmodule

>>> rtl/ppt_div.sv
// Restoring divider, one quotient bit per cycle, truncating.
// Depends on ppt_pkg for the divisor width.
module ppt_div #(
   parameter int N_W = 81
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [N_W-1:0]                dividend,
   input  logic [ppt_pkg::DIVISOR_W-1:0] divisor,
   output logic [N_W-1:0]                quotient,
   output logic                          busy
);
   import ppt_pkg::*;

   localparam int CW = $clog2(N_W);

   logic [N_W-1:0]       n_ff;
   logic [DIVISOR_W-1:0] d_ff;
   logic [DIVISOR_W-1:0] rem_ff;
   logic [CW-1:0]        cnt_ff;
   logic                 busy_ff;
   logic [DIVISOR_W:0]   trial;
   logic                 qbit;

   // bring down the next dividend bit and try a subtract
   assign trial = {rem_ff, n_ff[N_W-1]};
   assign qbit  = (trial >= {1'b0, d_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 1'b1;
         if (cnt_ff == CW'(N_W - 1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         n_ff   <= dividend;
         d_ff   <= divisor;
         rem_ff <= '0;
      end else if (busy_ff) begin
         rem_ff <= qbit ? DIVISOR_W'(trial - {1'b0, d_ff}) : DIVISOR_W'(trial);
         n_ff   <= {n_ff[N_W-2:0], qbit};
      end
   end

   assign quotient = n_ff;
   assign busy     = busy_ff;

endmodule

>>> rtl/ppt_dp.sv
// Datapath of the tracker: request registers, account table, fill and
// profit arithmetic, result register. Depends on ppt_pkg, ppt_mul, ppt_div.
module ppt_dp #(
   parameter int ACCOUNT_COUNT   = ppt_pkg::DEF_ACCOUNT_COUNT,
   parameter int PRICE_FRAC_BITS = ppt_pkg::DEF_PRICE_FRAC_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  ppt_pkg::cmd_type              cmd,
   output ppt_pkg::status_type           status,
   input  logic                          req_cmd,
   input  logic [ppt_pkg::ACCT_W-1:0]    req_aggressor_account,
   input  logic [ppt_pkg::ACCT_W-1:0]    req_resting_account,
   input  logic [ppt_pkg::PRICE_W-1:0]   req_trade_price,
   input  logic [ppt_pkg::VOL_W-1:0]     req_trade_volume,
   input  logic                          req_aggressor_sells,
   input  logic [ppt_pkg::ACCT_W-1:0]    req_query_account,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [ppt_pkg::POS_W-1:0] rsp_position,
   output logic [ppt_pkg::AVG_OUT_W-1:0] rsp_entry_price,
   output logic signed [ppt_pkg::PNL_W-1:0] rsp_booked_profit,
   output logic signed [ppt_pkg::PNL_W-1:0] rsp_open_profit,
   output logic [ppt_pkg::PRICE_W-1:0]   rsp_recent_price
);
   import ppt_pkg::*;

   localparam int AW     = $clog2(ACCOUNT_COUNT);
   localparam int IDX_W  = (AW > ACCT_W) ? AW : ACCT_W;
   localparam int PQ_W   = PRICE_W + PRICE_FRAC_BITS;
   localparam int PROD_W = PQ_W + MPLIER_W;
   localparam int TOT_W  = PROD_W + 1;
   localparam int SUM_W  = PROD_W + 2;
   localparam int ENT_W  = POS_W + PQ_W + PNL_W;
   localparam logic signed [PNL_W-1:0] PNL_MAX = {1'b0, {(PNL_W-1){1'b1}}};
   localparam logic signed [PNL_W-1:0] PNL_MIN = {1'b1, {(PNL_W-1){1'b0}}};

   // latched request
   logic               is_query_ff;
   logic [ACCT_W-1:0]  agg_ff, rest_ff, qacct_ff;
   logic [PRICE_W-1:0] price_ff;
   logic [VOL_W-1:0]   vol_ff;
   logic               sells_ff;
   logic               side_ff;
   logic [PRICE_W-1:0] recent_ff;

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         is_query_ff <= (req_cmd == CMD_QUERY);
         agg_ff      <= req_aggressor_account;
         rest_ff     <= req_resting_account;
         qacct_ff    <= req_query_account;
         price_ff    <= req_trade_price;
         vol_ff      <= req_trade_volume;
         sells_ff    <= req_aggressor_sells;
      end
   end

   // side select and last traded price
   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff   <= 1'b0;
         recent_ff <= '0;
      end else begin
         if (cmd.take) begin
            side_ff <= 1'b0;
            if (req_cmd == CMD_TRADE) begin
               recent_ff <= req_trade_price;
            end
         end else if (cmd.side_next) begin
            side_ff <= 1'b1;
         end
      end
   end

   // current account and range check
   logic [ACCT_W-1:0] cur_acct;
   logic [IDX_W-1:0]  cur_ext;
   logic [AW-1:0]     addr;
   logic              acct_ok;
   logic              sells_eff;

   assign cur_acct  = is_query_ff ? qacct_ff : (side_ff ? rest_ff : agg_ff);
   assign cur_ext   = IDX_W'(cur_acct);
   assign addr      = cur_ext[AW-1:0];
   assign acct_ok   = (32'(cur_acct) < 32'(ACCOUNT_COUNT));
   assign sells_eff = sells_ff ^ side_ff;

   // clearing sweep counter
   logic [AW-1:0] clr_cnt_ff;
   logic          clr_last;

   assign clr_last = (clr_cnt_ff == AW'(ACCOUNT_COUNT - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clr_step) begin
         clr_cnt_ff <= clr_cnt_ff + 1'b1;
      end
   end

   // account table: one write port, one registered read port
   logic [ENT_W-1:0] table_ff [ACCOUNT_COUNT];
   logic [ENT_W-1:0] rd_ff;
   logic [ENT_W-1:0] wr_data;
   logic [AW-1:0]    wr_addr;
   logic             wr_en;

   assign wr_en   = cmd.clr_step | cmd.wr;
   assign wr_addr = cmd.clr_step ? clr_cnt_ff : addr;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_ff[wr_addr] <= wr_data;
      end
      if (cmd.rd) begin
         rd_ff <= table_ff[addr];
      end
   end

   // decode the entry just read
   logic signed [POS_W-1:0] inv;
   logic [PQ_W-1:0]         avg;
   logic signed [PNL_W-1:0] booked;

   assign inv    = rd_ff[ENT_W-1 -: POS_W];
   assign avg    = rd_ff[PNL_W +: PQ_W];
   assign booked = rd_ff[PNL_W-1:0];

   // fill terms
   logic [PQ_W-1:0]         price_q, last_q, ref_q, diff;
   logic                    up;
   logic [MPLIER_W-1:0]     ainv, vol32, close;
   logic signed [33:0]      sv, ninv;
   logic                    pnl_neg;
   logic [1:0]              kind;
   logic                    open_nz;

   assign price_q = PQ_W'(price_ff) << PRICE_FRAC_BITS;
   assign last_q  = PQ_W'(recent_ff) << PRICE_FRAC_BITS;
   assign ref_q   = is_query_ff ? last_q : price_q;
   assign up      = (ref_q >= avg);
   assign diff    = up ? (ref_q - avg) : (avg - ref_q);
   assign ainv    = inv[POS_W-1] ? MPLIER_W'(-inv) : MPLIER_W'(inv);
   assign vol32   = MPLIER_W'(vol_ff);
   assign close   = (vol32 < ainv) ? vol32 : ainv;
   assign sv      = sells_eff ? -$signed({3'b000, vol_ff}) : $signed({3'b000, vol_ff});
   assign ninv    = 34'(inv) + sv;
   // a loss on a long when price falls, on a short when it rises
   assign pnl_neg = inv[POS_W-1] ? up : ~up;
   assign open_nz = (inv != 0) && (recent_ff != 0) && (avg != 0);

   always_comb begin
      if (inv == 0) begin
         kind = KIND_OPEN;
      end else if ((vol_ff != 0) && (inv[POS_W-1] == sells_eff)) begin
         kind = KIND_ADD;
      end else begin
         kind = KIND_REDUCE;
      end
   end

   // shared multiplier operand select
   logic [PQ_W-1:0]     mcand;
   logic [MPLIER_W-1:0] mplier;
   logic [PROD_W-1:0]   prod;
   logic                mul_busy;

   always_comb begin
      case (cmd.mul_sel)
         MSEL_ENTRY: begin
            mcand  = avg;
            mplier = ainv;
         end
         MSEL_FILL: begin
            mcand  = price_q;
            mplier = vol32;
         end
         MSEL_CLOSE: begin
            mcand  = diff;
            mplier = close;
         end
         default: begin
            mcand  = diff;
            mplier = ainv;
         end
      endcase
   end

   ppt_mul #(.A_W(PQ_W)) u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.mul_start),
      .mcand  (mcand),
      .mplier (mplier),
      .prod   (prod),
      .busy   (mul_busy)
   );

   // hold the first product of a weighted average
   logic [PROD_W-1:0] prod_a_ff;

   always_ff @(posedge clock) begin
      if (cmd.save_a) begin
         prod_a_ff <= prod;
      end
   end

   // weighted average divider
   logic [TOT_W-1:0] total, quot;
   logic             div_busy;

   assign total = TOT_W'(prod_a_ff) + TOT_W'(prod);

   ppt_div #(.N_W(TOT_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (total),
      .divisor  (ainv + vol32),
      .quotient (quot),
      .busy     (div_busy)
   );

   // saturating profit add; the open profit starts from zero
   logic signed [SUM_W-1:0] acc_ext, mag_ext, sum;
   logic signed [PNL_W-1:0] sat;
   logic [SUM_W-PNL_W:0]    top;

   assign acc_ext = is_query_ff ? '0 : SUM_W'(booked);
   assign mag_ext = $signed({2'b00, prod});
   assign sum     = pnl_neg ? (acc_ext - mag_ext) : (acc_ext + mag_ext);
   assign top     = sum[SUM_W-1:PNL_W-1];

   always_comb begin
      if ((top == '0) || (top == '1)) begin
         sat = sum[PNL_W-1:0];
      end else begin
         sat = sum[SUM_W-1] ? PNL_MIN : PNL_MAX;
      end
   end

   // build the entry to write back
   logic signed [POS_W-1:0] new_pos;
   logic [PQ_W-1:0]         new_avg;
   logic signed [PNL_W-1:0] new_booked;

   always_comb begin
      new_pos    = inv;
      new_avg    = avg;
      new_booked = booked;
      case (kind)
         KIND_OPEN: begin
            new_pos = sv[POS_W-1:0];
            new_avg = price_q;
         end
         KIND_ADD: begin
            new_avg = quot[PQ_W-1:0];
            if (ninv > 34'sh07FFFFFFF) begin
               new_pos = {1'b0, {(POS_W-1){1'b1}}};
            end else if (ninv < -34'sh080000000) begin
               new_pos = {1'b1, {(POS_W-1){1'b0}}};
            end else begin
               new_pos = ninv[POS_W-1:0];
            end
         end
         default: begin
            new_booked = sat;
            if (ninv == 0) begin
               new_pos = '0;
               new_avg = '0;
            end else begin
               new_pos = ninv[POS_W-1:0];
               // take the trade price when the position changes side
               if (inv[POS_W-1] != ninv[33]) begin
                  new_avg = price_q;
               end
            end
         end
      endcase
   end

   assign wr_data = cmd.clr_step ? '0 : {new_pos, new_avg, new_booked};

   // result register
   logic                    rsp_valid_ff;
   logic signed [POS_W-1:0] rsp_pos_ff;
   logic [AVG_OUT_W-1:0]    rsp_avg_ff;
   logic signed [PNL_W-1:0] rsp_booked_ff, rsp_open_ff;
   logic [PRICE_W-1:0]      rsp_recent_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_recent_ff <= recent_ff;
         if (acct_ok) begin
            rsp_pos_ff    <= inv;
            rsp_avg_ff    <= AVG_OUT_W'(avg);
            rsp_booked_ff <= booked;
            rsp_open_ff   <= open_nz ? sat : '0;
         end else begin
            rsp_pos_ff    <= '0;
            rsp_avg_ff    <= '0;
            rsp_booked_ff <= '0;
            rsp_open_ff   <= '0;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_position      = rsp_pos_ff;
   assign rsp_entry_price   = rsp_avg_ff;
   assign rsp_booked_profit = rsp_booked_ff;
   assign rsp_open_profit   = rsp_open_ff;
   assign rsp_recent_price  = rsp_recent_ff;

   // status to the controller
   assign status.clr_done = clr_last;
   assign status.is_query = is_query_ff;
   assign status.side     = side_ff;
   assign status.acct_ok  = acct_ok;
   assign status.kind     = kind;
   assign status.open_nz  = open_nz;
   assign status.mul_done = ~mul_busy;
   assign status.div_done = ~div_busy;
   assign status.rsp_free = ~rsp_valid_ff | rsp_ready;

endmodule

>>> rtl/ppt_ctrl.sv
// Controller of the tracker: sequences clearing, fills and queries.
// Depends on ppt_pkg for the command and status structs.
module ppt_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  ppt_pkg::status_type status,
   output ppt_pkg::cmd_type    cmd
);
   import ppt_pkg::*;

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_PICK  = 4'd2;
   localparam logic [3:0] S_EVAL  = 4'd3;
   localparam logic [3:0] S_MULA  = 4'd4;
   localparam logic [3:0] S_MULB  = 4'd5;
   localparam logic [3:0] S_DIV   = 4'd6;
   localparam logic [3:0] S_WRITE = 4'd7;
   localparam logic [3:0] S_RESP  = 4'd8;

   logic [3:0] state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (status.clr_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.take = 1'b1;
               state_in = S_PICK;
            end
         end
         S_PICK: begin
            if (status.acct_ok) begin
               cmd.rd   = 1'b1;
               state_in = S_EVAL;
            end else if (status.is_query) begin
               state_in = S_RESP;
            end else if (!status.side) begin
               cmd.side_next = 1'b1;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_EVAL: begin
            if (status.is_query) begin
               if (status.open_nz) begin
                  cmd.mul_start = 1'b1;
                  cmd.mul_sel   = MSEL_OPEN;
                  state_in      = S_MULA;
               end else begin
                  state_in = S_RESP;
               end
            end else begin
               case (status.kind)
                  KIND_OPEN: begin
                     state_in = S_WRITE;
                  end
                  KIND_ADD: begin
                     cmd.mul_start = 1'b1;
                     cmd.mul_sel   = MSEL_ENTRY;
                     state_in      = S_MULA;
                  end
                  default: begin
                     cmd.mul_start = 1'b1;
                     cmd.mul_sel   = MSEL_CLOSE;
                     state_in      = S_MULA;
                  end
               endcase
            end
         end
         S_MULA: begin
            if (status.mul_done) begin
               if (status.is_query) begin
                  state_in = S_RESP;
               end else if (status.kind == KIND_ADD) begin
                  cmd.save_a    = 1'b1;
                  cmd.mul_start = 1'b1;
                  cmd.mul_sel   = MSEL_FILL;
                  state_in      = S_MULB;
               end else begin
                  state_in = S_WRITE;
               end
            end
         end
         S_MULB: begin
            if (status.mul_done) begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV;
            end
         end
         S_DIV: begin
            if (status.div_done) begin
               state_in = S_WRITE;
            end
         end
         S_WRITE: begin
            cmd.wr = 1'b1;
            if (!status.side) begin
               cmd.side_next = 1'b1;
               state_in      = S_PICK;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_RESP: begin
            if (status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

>>> rtl/position_pnl_tracker.sv
// Top level of the average-cost position and profit tracker.
// Depends on ppt_pkg, ppt_ctrl and ppt_dp.
//
// One request at a time. After reset the account table is swept to zero,
// with req_ready low. Unrealized profit for a query, when it must be formed,
// comes from the 32-step shift-add multiplier. A trade takes up to two
// account updates; an update that adds to a position runs the multiplier
// twice and the one-bit-a-cycle divider over 65+PRICE_FRAC_BITS bits. A
// waiting result does not block the next request; a query then holds in
// place until the result register frees up.
module position_pnl_tracker #(
   parameter int ACCOUNT_COUNT   = ppt_pkg::DEF_ACCOUNT_COUNT,
   parameter int PRICE_FRAC_BITS = ppt_pkg::DEF_PRICE_FRAC_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_cmd,
   input  logic [ppt_pkg::ACCT_W-1:0]    req_aggressor_account,
   input  logic [ppt_pkg::ACCT_W-1:0]    req_resting_account,
   input  logic [ppt_pkg::PRICE_W-1:0]   req_trade_price,
   input  logic [ppt_pkg::VOL_W-1:0]     req_trade_volume,
   input  logic                          req_aggressor_sells,
   input  logic [ppt_pkg::ACCT_W-1:0]    req_query_account,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [ppt_pkg::POS_W-1:0] rsp_position,
   output logic [ppt_pkg::AVG_OUT_W-1:0] rsp_entry_price,
   output logic signed [ppt_pkg::PNL_W-1:0] rsp_booked_profit,
   output logic signed [ppt_pkg::PNL_W-1:0] rsp_open_profit,
   output logic [ppt_pkg::PRICE_W-1:0]   rsp_recent_price
);
   import ppt_pkg::*;

   cmd_type    cmd;
   status_type status;

   ppt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   ppt_dp #(
      .ACCOUNT_COUNT   (ACCOUNT_COUNT),
      .PRICE_FRAC_BITS (PRICE_FRAC_BITS)
   ) u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .status                (status),
      .req_cmd               (req_cmd),
      .req_aggressor_account (req_aggressor_account),
      .req_resting_account   (req_resting_account),
      .req_trade_price       (req_trade_price),
      .req_trade_volume      (req_trade_volume),
      .req_aggressor_sells   (req_aggressor_sells),
      .req_query_account     (req_query_account),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_position          (rsp_position),
      .rsp_entry_price       (rsp_entry_price),
      .rsp_booked_profit     (rsp_booked_profit),
      .rsp_open_profit       (rsp_open_profit),
      .rsp_recent_price      (rsp_recent_price)
   );

endmodule

>>> rtl/ppt_checker.sv
// Port-level checks for the tracker, bound to the top level.
// Depends on ppt_pkg for field widths.
module ppt_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic signed [ppt_pkg::POS_W-1:0] rsp_position,
   input logic signed [ppt_pkg::PNL_W-1:0] rsp_open_profit,
   input logic [ppt_pkg::PRICE_W-1:0]   rsp_recent_price
);

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // table sweep keeps requests out right after reset
   a_clear: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request taken during table clear");

   // one request at a time
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // open profit needs inventory and a traded price
   a_open: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_open_profit != 0) |-> (rsp_position != 0) && (rsp_recent_price != 0))
      else $error("open profit without inventory or price");

endmodule

bind position_pnl_tracker ppt_checker u_ppt_checker (.*);
